// ===== sv/ttb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants of the triangle tangent basis unit
// Holds the triangle record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int unsigned IDX_W      = 16;  // index field width on the ports
  localparam int unsigned INDEX_BITS = 16;  // default kept index bits
  localparam int unsigned POS_W      = 32;
  localparam int unsigned TEX_W      = 16;
  localparam int unsigned DP_W       = POS_W + 1;  // position delta
  localparam int unsigned DT_W       = TEX_W + 1;  // texture delta
  localparam int unsigned QUEUE_DEPTH = 2;

  // One closed triangle: indices and exact edge deltas.
  typedef struct packed {
    logic [IDX_W-1:0]          idx_a;
    logic [IDX_W-1:0]          idx_b;
    logic [IDX_W-1:0]          idx_c;
    logic [2:0][DP_W-1:0]      dp1;
    logic [2:0][DP_W-1:0]      dp2;
    logic [DT_W-1:0]           t1u;
    logic [DT_W-1:0]           t1v;
    logic [DT_W-1:0]           t2u;
    logic [DT_W-1:0]           t2v;
  } tri_rec_t;

endpackage

// ===== sv/ttb_if.sv =====
// ----------------------------------------------------------------------------
// ttb_if: channel interfaces of the triangle tangent basis unit
// A corner input channel and a result output channel, valid/ready each.
// ----------------------------------------------------------------------------
interface corner_if;
  logic        valid;
  logic        ready;
  logic [15:0] vertex_index;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [15:0] tex_u;
  logic [15:0] tex_v;

  modport source (output valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                  input ready);
  modport sink (input valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                output ready);
endinterface

interface basis_if;
  logic        valid;
  logic        ready;
  logic [15:0] corner_a;
  logic [15:0] corner_b;
  logic [15:0] corner_c;
  logic [31:0] tangent_x;
  logic [31:0] tangent_y;
  logic [31:0] tangent_z;
  logic [31:0] bitangent_x;
  logic [31:0] bitangent_y;
  logic [31:0] bitangent_z;
  logic        degenerate;

  modport source (output valid, corner_a, corner_b, corner_c, tangent_x, tangent_y,
                  tangent_z, bitangent_x, bitangent_y, bitangent_z, degenerate,
                  input ready);
  modport sink (input valid, corner_a, corner_b, corner_c, tangent_x, tangent_y,
                tangent_z, bitangent_x, bitangent_y, bitangent_z, degenerate,
                output ready);
endinterface

// ===== sv/ttb_front.sv =====
// ----------------------------------------------------------------------------
// ttb_front: corner collector
// Holds the first two corners of a triangle and, on the third, forms the
// edge deltas and pushes a triangle record into the queue.
// ----------------------------------------------------------------------------
module ttb_front import ttb_pkg::*; #(
  parameter int unsigned IndexBits = INDEX_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  corner_if.sink       corner_i,
  input  logic         full_i,
  output logic         push_o,
  output tri_rec_t     rec_o
);

  localparam int unsigned KeepBits = (IndexBits < IDX_W) ? IndexBits : IDX_W;
  localparam logic [IDX_W-1:0] IdxMask = IDX_W'((64'd1 << KeepBits) - 64'd1);

  logic [1:0]             count_q, count_d;
  logic [IDX_W-1:0]       idx_q [2];
  logic [2:0][POS_W-1:0]  pos_q [2];
  logic [TEX_W-1:0]       u_q [2];
  logic [TEX_W-1:0]       v_q [2];
  logic                   xfer;
  logic [2:0][POS_W-1:0]  pos_in;
  logic [IDX_W-1:0]       idx_in;

  assign corner_i.ready = !full_i;
  assign xfer   = corner_i.valid && corner_i.ready;
  assign pos_in = {corner_i.pos_z, corner_i.pos_y, corner_i.pos_x};
  assign idx_in = corner_i.vertex_index & IdxMask;

  // Corner counter: two held corners, the third closes the triangle.
  always_comb begin
    count_d = count_q;
    if (xfer) begin
      count_d = (count_q == 2'd2) ? 2'd0 : count_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // Holding registers for corners A and B.
  always_ff @(posedge clk_i) begin
    if (xfer && count_q != 2'd2) begin
      idx_q[count_q[0]] <= idx_in;
      pos_q[count_q[0]] <= pos_in;
      u_q[count_q[0]]   <= corner_i.tex_u;
      v_q[count_q[0]]   <= corner_i.tex_v;
    end
  end

  // Record for the back end, built from the held corners and the current one.
  always_comb begin
    rec_o.idx_a = idx_q[0];
    rec_o.idx_b = idx_q[1];
    rec_o.idx_c = idx_in;
    for (int k = 0; k < 3; k++) begin
      rec_o.dp1[k] = DP_W'($signed(pos_q[1][k]) - $signed(pos_q[0][k]));
      rec_o.dp2[k] = DP_W'($signed(pos_in[k]) - $signed(pos_q[0][k]));
    end
    rec_o.t1u = DT_W'($signed(u_q[1]) - $signed(u_q[0]));
    rec_o.t1v = DT_W'($signed(v_q[1]) - $signed(v_q[0]));
    rec_o.t2u = DT_W'($signed(corner_i.tex_u) - $signed(u_q[0]));
    rec_o.t2v = DT_W'($signed(corner_i.tex_v) - $signed(v_q[0]));
  end

  assign push_o = xfer && (count_q == 2'd2);

endmodule

// ===== sv/ttb_queue.sv =====
// ----------------------------------------------------------------------------
// ttb_queue: triangle record queue
// A short register queue that decouples the collector from the solver.
// ----------------------------------------------------------------------------
module ttb_queue import ttb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tri_rec_t  rec_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      pop_i,
  output tri_rec_t  rec_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  tri_rec_t              mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]       wr_q, rd_q;
  logic [PtrW:0]         cnt_q;
  logic                  do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign rec_o   = mem_q[rd_q];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(do_pop);
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

endmodule

// ===== sv/ttb_back.sv =====
// ----------------------------------------------------------------------------
// ttb_back: tangent basis solver
// Sequencer around one pair of multipliers and one radix-2 divider; computes
// the determinant, six numerators and six rounded, saturated quotients.
// ----------------------------------------------------------------------------
module ttb_back import ttb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  tri_rec_t  rec_i,
  output logic      pop_o,
  basis_if.source   basis_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DET  = 4'd1;
  localparam logic [3:0] S_DETC = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_NUM  = 4'd4;
  localparam logic [3:0] S_PREP = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam int unsigned PW  = DP_W + DT_W;  // product width
  localparam int unsigned NW  = PW + 1;       // numerator width
  localparam int unsigned DW  = 2*DT_W + 1;   // determinant width
  localparam int unsigned NNW = NW - 1 + 12;  // scaled magnitude width
  localparam int unsigned QW  = 33;           // quotient bits kept
  localparam int unsigned RW  = DW + 1;       // remainder width

  logic [3:0]               state_q;
  tri_rec_t                 rec_q;
  logic [2:0]               comp_q;
  logic signed [DP_W-1:0]   ma0, ma1;
  logic signed [DT_W-1:0]   mb0, mb1;
  logic signed [PW-1:0]     pa_q, pb_q;
  logic signed [DW-1:0]     det_q;
  logic signed [NW-1:0]     num_q;
  logic signed [NW:0]       num_diff;
  logic signed [PW:0]       det_diff;
  logic [NW-2+1:0]          nm;
  logic [DW-1:0]            dm;
  logic [NNW:0]             nn;
  logic [NNW:0]             nn_q;
  logic [DW-1:0]            dm_q;
  logic [RW-1:0]            rem_q;
  logic [RW-1:0]            rem_sh;
  logic [QW-1:0]            quo_q;
  logic [5:0]               cnt_q;
  logic                     neg_q, ovf_q, deg_q;
  logic [31:0]              res_q [6];
  logic [31:0]              sat;
  logic [1:0]               k;
  logic                     out_free;

  assign out_free = !basis_o.valid || basis_o.ready;
  assign pop_o    = (state_q == S_IDLE) && valid_i;
  assign k        = (comp_q < 3'd3) ? comp_q[1:0] : 2'(comp_q - 3'd3);

  // Multiplier operand selection: determinant first, then each component.
  always_comb begin
    ma0 = DP_W'($signed(rec_q.t1u));
    mb0 = $signed(rec_q.t2v);
    ma1 = DP_W'($signed(rec_q.t1v));
    mb1 = $signed(rec_q.t2u);
    if (state_q == S_MUL) begin
      if (comp_q < 3'd3) begin
        ma0 = $signed(rec_q.dp1[k]);
        mb0 = $signed(rec_q.t2v);
        ma1 = $signed(rec_q.dp2[k]);
        mb1 = $signed(rec_q.t1v);
      end else begin
        ma0 = $signed(rec_q.dp2[k]);
        mb0 = $signed(rec_q.t1u);
        ma1 = $signed(rec_q.dp1[k]);
        mb1 = $signed(rec_q.t2u);
      end
    end
  end

  // Registered products.
  always_ff @(posedge clk_i) begin
    pa_q <= ma0 * mb0;
    pb_q <= ma1 * mb1;
  end

  // Datapath helpers.
  assign det_diff = (PW+1)'(pa_q) - (PW+1)'(pb_q);
  assign num_diff = (NW+1)'(pa_q) - (NW+1)'(pb_q);
  assign nm = num_q[NW-1] ? (NW)'(-num_q) : (NW)'(num_q);
  assign dm = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
  assign nn = {nm[NW-2:0], 12'd0} + (NNW+1)'(dm >> 1);
  assign rem_sh = {rem_q[RW-2:0], nn_q[cnt_q]};

  // Round-to-nearest quotient, saturated to the signed 32-bit range.
  always_comb begin
    if (ovf_q) begin
      sat = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (neg_q) begin
      sat = (quo_q > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-quo_q);
    end else begin
      sat = (quo_q > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : quo_q[31:0];
    end
  end

  // Result valid: set when a result is loaded, cleared after its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basis_o.valid <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      basis_o.valid <= 1'b1;
    end else if (basis_o.valid && basis_o.ready) begin
      basis_o.valid <= 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      comp_q  <= '0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (valid_i) begin
            comp_q  <= '0;
            state_q <= S_DET;
          end
        end
        S_DET:  state_q <= S_DETC;
        S_DETC: state_q <= (det_diff == '0) ? S_OUT : S_MUL;
        S_MUL:  state_q <= S_NUM;
        S_NUM:  state_q <= S_PREP;
        S_PREP: begin
          cnt_q   <= 6'(QW - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (ovf_q || cnt_q == '0) begin
            state_q <= S_FIN;
          end
          cnt_q <= cnt_q - 6'd1;
        end
        S_FIN: begin
          if (comp_q == 3'd5) begin
            state_q <= S_OUT;
          end else begin
            comp_q  <= comp_q + 3'd1;
            state_q <= S_MUL;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          rec_q <= rec_i;
        end
      end
      S_DETC: begin
        det_q <= DW'(det_diff);
        deg_q <= (det_diff == '0);
        for (int i = 0; i < 6; i++) begin
          res_q[i] <= '0;
        end
      end
      S_NUM: num_q <= NW'(num_diff);
      S_PREP: begin
        neg_q <= num_q[NW-1] ^ det_q[DW-1];
        nn_q  <= nn;
        dm_q  <= dm;
        ovf_q <= ({5'd0, nn} >= ({(DW+QW)'(dm)} << QW));
        rem_q <= RW'(nn[NNW:QW]);
        quo_q <= '0;
      end
      S_DIV: begin
        if (rem_sh >= RW'(dm_q)) begin
          rem_q <= rem_sh - RW'(dm_q);
          quo_q <= {quo_q[QW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[QW-2:0], 1'b0};
        end
      end
      S_FIN: res_q[comp_q] <= sat;
      S_OUT: begin
        if (out_free) begin
          basis_o.corner_a    <= rec_q.idx_a;
          basis_o.corner_b    <= rec_q.idx_b;
          basis_o.corner_c    <= rec_q.idx_c;
          basis_o.tangent_x   <= res_q[0];
          basis_o.tangent_y   <= res_q[1];
          basis_o.tangent_z   <= res_q[2];
          basis_o.bitangent_x <= res_q[3];
          basis_o.bitangent_y <= res_q[4];
          basis_o.bitangent_z <= res_q[5];
          basis_o.degenerate  <= deg_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/triangle_tangent_basis.sv =====
// ----------------------------------------------------------------------------
// triangle_tangent_basis: per-triangle tangent and bitangent from uv
// Collects triangle-list corners and solves each closed triangle.
// ----------------------------------------------------------------------------
//  Channel    Dir  Transfer unit
//  corner_i   in   one corner: index, xyz position (Q16.16), uv (Q4.12)
//  basis_o    out  one triangle: three indices, tangent, bitangent, degenerate
//
// A corner transfers in any cycle in which the queue has room.
// In the solver, each triangle goes from the queue read to the result register
// through these steps: form the determinant, then per component multiply and
// set up, run the shared radix-2 divider (stopped early when the quotient
// overflows) and saturate, and finally load the result. A zero determinant
// skips the divider. The queue holds two triangles, so the collector stalls
// only when the solver falls behind.
// Reset is async.
// ----------------------------------------------------------------------------
module triangle_tangent_basis import ttb_pkg::*; #(
  parameter int unsigned IndexBits = INDEX_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  corner_if.sink   corner_i,
  basis_if.source  basis_o
);

  logic       q_push, q_full;
  tri_rec_t   rec_in, rec_out;
  logic       q_valid, q_pop;

  ttb_front #(.IndexBits(IndexBits)) u_front (
    .clk_i, .rst_ni, .corner_i,
    .full_i (q_full),
    .push_o (q_push),
    .rec_o  (rec_in)
  );

  ttb_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .rec_i   (rec_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .rec_o   (rec_out)
  );

  ttb_back u_back (
    .clk_i, .rst_ni,
    .valid_i (q_valid),
    .rec_i   (rec_out),
    .pop_o   (q_pop),
    .basis_o
  );

  // The queue is never written while full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full)) else $error("triangle queue overflow");

  // The collector only stalls on a full queue.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !corner_i.ready |-> q_full) else $error("corner stall without cause");

  // A degenerate triangle carries zero vectors.
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (basis_o.valid && basis_o.degenerate) |->
      (basis_o.tangent_x == '0 && basis_o.tangent_y == '0 &&
       basis_o.tangent_z == '0 && basis_o.bitangent_x == '0 &&
       basis_o.bitangent_y == '0 && basis_o.bitangent_z == '0))
    else $error("degenerate result with nonzero vector");

endmodule

// ===== tb/tb_triangle_tangent_basis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_tangent_basis: self-checking bench of the tangent basis unit
// Streams triangle-list corners into the unit, computes each triangle's
// tangent, bitangent and degenerate flag in the bench, and compares every
// result transfer field by field, under random idling and a long output stall.
// ----------------------------------------------------------------------------
module tb_triangle_tangent_basis;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned MaxReports = 10;

  // One expected triangle result.
  typedef struct packed {
    logic [15:0] corner_a;
    logic [15:0] corner_b;
    logic [15:0] corner_c;
    logic [31:0] tangent_x;
    logic [31:0] tangent_y;
    logic [31:0] tangent_z;
    logic [31:0] bitangent_x;
    logic [31:0] bitangent_y;
    logic [31:0] bitangent_z;
    logic        degenerate;
  } basis_t;

  logic clk_i;
  logic rst_ni;

  corner_if corner_ch ();
  basis_if  basis_ch ();

  triangle_tangent_basis DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .corner_i(corner_ch),
    .basis_o (basis_ch)
  );

  // Bench copy of the corner collector.
  int unsigned   held_count;
  logic [31:0]   held_pos [2][3];
  logic [15:0]   held_uv  [2][2];
  logic [15:0]   held_idx [2];
  basis_t        pending_bases[$];

  int unsigned   mismatch_count;
  bit            steady_flow;
  int unsigned   stall_cycles;
  longint unsigned cycle_count;

  // Clock and cycle limit.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Rounded, saturated Q16.16 quotient of a Q.28 numerator and Q8.24 divisor.
  function automatic logic [31:0] div_round_sat(longint num, longint det);
    bit neg;
    longint unsigned nm, dm, q;
    neg = (num < 0) != (det < 0);
    nm  = (num < 0) ? longint'(-num) : num;
    dm  = (det < 0) ? longint'(-det) : det;
    nm  = nm << 12;
    q   = (nm + dm / 2) / dm;
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return 32'(q);
  endfunction

  // Track one accepted corner; a third corner yields an expected result.
  function automatic void collect_corner(logic [15:0] idx, logic [31:0] px, logic [31:0] py,
                                         logic [31:0] pz, logic [15:0] u, logic [15:0] v);
    basis_t r;
    longint dp1 [3];
    longint dp2 [3];
    longint t1u, t1v, t2u, t2v, det;
    logic [31:0] cur [3];
    logic [31:0] tang [3];
    logic [31:0] bitang [3];
    cur = '{px, py, pz};
    if (held_count < 2) begin
      held_idx[held_count] = idx;
      held_pos[held_count] = cur;
      held_uv[held_count]  = '{u, v};
      held_count++;
      return;
    end
    held_count = 0;
    for (int k = 0; k < 3; k++) begin
      dp1[k] = longint'($signed(held_pos[1][k])) - longint'($signed(held_pos[0][k]));
      dp2[k] = longint'($signed(cur[k])) - longint'($signed(held_pos[0][k]));
    end
    t1u = longint'($signed(held_uv[1][0])) - longint'($signed(held_uv[0][0]));
    t1v = longint'($signed(held_uv[1][1])) - longint'($signed(held_uv[0][1]));
    t2u = longint'($signed(u)) - longint'($signed(held_uv[0][0]));
    t2v = longint'($signed(v)) - longint'($signed(held_uv[0][1]));
    det = t1u * t2v - t1v * t2u;
    for (int k = 0; k < 3; k++) begin
      tang[k]   = (det == 0) ? '0 : div_round_sat(dp1[k] * t2v - dp2[k] * t1v, det);
      bitang[k] = (det == 0) ? '0 : div_round_sat(t1u * dp2[k] - dp1[k] * t2u, det);
    end
    r.corner_a    = held_idx[0];
    r.corner_b    = held_idx[1];
    r.corner_c    = idx;
    r.tangent_x   = tang[0];
    r.tangent_y   = tang[1];
    r.tangent_z   = tang[2];
    r.bitangent_x = bitang[0];
    r.bitangent_y = bitang[1];
    r.bitangent_z = bitang[2];
    r.degenerate  = (det == 0);
    pending_bases.insert(pending_bases.size(), r);
  endfunction

  // Offer one corner until it transfers, idling at random first unless steady.
  task automatic send_corner(logic [15:0] idx, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz, logic [15:0] u, logic [15:0] v);
    if (!steady_flow) begin
      while ($urandom_range(99) < 36) begin
        corner_ch.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    corner_ch.valid        <= 1'b1;
    corner_ch.vertex_index <= idx;
    corner_ch.pos_x        <= px;
    corner_ch.pos_y        <= py;
    corner_ch.pos_z        <= pz;
    corner_ch.tex_u        <= u;
    corner_ch.tex_v        <= v;
    @(posedge clk_i);
    while (!corner_ch.ready) @(posedge clk_i);
    collect_corner(idx, px, py, pz, u, v);
    @(negedge clk_i);
  endtask

  // Result side: random ready, or a counted hold-off when one is requested.
  always @(negedge clk_i) begin
    if (stall_cycles > 0) begin
      stall_cycles--;
      basis_ch.ready <= 1'b0;
    end else begin
      basis_ch.ready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 36);
    end
  end

  // Compare every result transfer against the oldest expected triangle.
  always @(posedge clk_i) begin
    basis_t got, want;
    logic [31:0] got_f [10];
    logic [31:0] want_f [10];
    string names [10];
    if (rst_ni && basis_ch.valid && basis_ch.ready) begin
      got = '{basis_ch.corner_a, basis_ch.corner_b, basis_ch.corner_c,
              basis_ch.tangent_x, basis_ch.tangent_y, basis_ch.tangent_z,
              basis_ch.bitangent_x, basis_ch.bitangent_y, basis_ch.bitangent_z,
              basis_ch.degenerate};
      if (pending_bases.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("Unexpected result transfer: %p", got);
      end else begin
        want   = pending_bases[0];
        pending_bases.delete(0);
        names  = '{"corner_a", "corner_b", "corner_c", "tangent_x", "tangent_y",
                   "tangent_z", "bitangent_x", "bitangent_y", "bitangent_z", "degenerate"};
        got_f  = '{got.corner_a, got.corner_b, got.corner_c, got.tangent_x, got.tangent_y,
                   got.tangent_z, got.bitangent_x, got.bitangent_y, got.bitangent_z,
                   got.degenerate};
        want_f = '{want.corner_a, want.corner_b, want.corner_c, want.tangent_x,
                   want.tangent_y, want.tangent_z, want.bitangent_x, want.bitangent_y,
                   want.bitangent_z, want.degenerate};
        for (int k = 0; k < 10; k++) begin
          if (got_f[k] !== want_f[k]) begin
            mismatch_count++;
            if (mismatch_count <= MaxReports)
              $display("Mismatch on %s: expected %h, got %h", names[k], want_f[k], got_f[k]);
          end
        end
      end
    end
  end

  // Random position: mostly small values, sometimes any 32-bit pattern.
  function automatic logic [31:0] rand_pos();
    if ($urandom_range(99) < 15) return $urandom;
    return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
  endfunction

  // Random texture coordinate: mostly within the unit square, sometimes anything.
  function automatic logic [15:0] rand_uv();
    if ($urandom_range(99) < 15) return 16'($urandom);
    return 16'($urandom_range(4096));
  endfunction

  // Corners at the corners of the value ranges, plus the degenerate case.
  task automatic test_directed();
    // Right triangle with a unit uv mapping.
    send_corner(16'h0000, 32'h0, 32'h0, 32'h0, 16'h0000, 16'h0000);
    send_corner(16'hFFFF, 32'h0001_0000, 32'h0, 32'h0, 16'h1000, 16'h0000);
    send_corner(16'h5A5A, 32'h0, 32'h0001_0000, 32'h0, 16'h0000, 16'h1000);
    // All three corners share one uv, so the determinant is zero.
    send_corner(16'h1234, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000, 16'h0800, 16'h0800);
    send_corner(16'h0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 16'h0800, 16'h0800);
    send_corner(16'hFFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h0800, 16'h0800);
    // Extreme position deltas over a tiny uv area: saturates both ways.
    send_corner(16'hA5A5, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'h0000, 16'h0000);
    send_corner(16'h8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'h0001, 16'h0000);
    send_corner(16'h7FFF, 32'h0, 32'h0, 32'h8000_0000, 16'h0000, 16'h0001);
    // Extreme uv values.
    send_corner(16'h00FF, 32'h0010_0000, 32'hFFF0_0000, 32'h0, 16'h8000, 16'h8000);
    send_corner(16'hFF00, 32'hFFF0_0000, 32'h0010_0000, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000);
    send_corner(16'h0F0F, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h7FFF);
    // Determinant of three units: quotients that need rounding.
    send_corner(16'h0002, 32'h0001_0000, 32'h0002_0000, 32'h0000_0001, 16'h0000, 16'h0000);
    send_corner(16'h0003, 32'h0005_1234, 32'hFFFE_0000, 32'h0000_0002, 16'h0003, 16'h0000);
    send_corner(16'h0004, 32'hFFFF_FFFF, 32'h0000_0007, 32'h0001_0001, 16'h0000, 16'h0001);
    // Mirrored mapping: negative determinant.
    send_corner(16'h0005, 32'h0, 32'h0, 32'h0, 16'h0000, 16'h0000);
    send_corner(16'h0006, 32'h0, 32'h0001_0000, 32'h0, 16'h0000, 16'h1000);
    send_corner(16'h0007, 32'h0001_0000, 32'h0, 32'h0002_0000, 16'h1000, 16'h0000);
  endtask

  // Random triangles; some reuse one uv to hit the degenerate case.
  task automatic test_random(int unsigned triangles);
    logic [15:0] u0, v0;
    for (int t = 0; t < triangles; t++) begin
      steady_flow = (t < 120);
      u0 = rand_uv();
      v0 = rand_uv();
      send_corner(16'($urandom), rand_pos(), rand_pos(), rand_pos(), u0, v0);
      if ($urandom_range(99) < 8) begin
        send_corner(16'($urandom), rand_pos(), rand_pos(), rand_pos(), u0, v0);
        send_corner(16'($urandom), rand_pos(), rand_pos(), rand_pos(), rand_uv(), rand_uv());
      end else begin
        send_corner(16'($urandom), rand_pos(), rand_pos(), rand_pos(), rand_uv(), rand_uv());
        send_corner(16'($urandom), rand_pos(), rand_pos(), rand_pos(), rand_uv(), rand_uv());
      end
    end
    steady_flow = 1'b0;
  endtask

  // Hold the result side off while corners keep coming, so the input stalls.
  task automatic test_output_stall();
    stall_cycles = 2000;
    for (int t = 0; t < 12; t++) begin
      send_corner(16'($urandom), rand_pos(), rand_pos(), rand_pos(), rand_uv(), rand_uv());
      send_corner(16'($urandom), rand_pos(), rand_pos(), rand_pos(), rand_uv(), rand_uv());
      send_corner(16'($urandom), rand_pos(), rand_pos(), rand_pos(), rand_uv(), rand_uv());
    end
  endtask

  // Sequence the tests and judge the run.
  initial begin
    rst_ni                 = 1'b0;
    corner_ch.valid        = 1'b0;
    corner_ch.vertex_index = '0;
    corner_ch.pos_x        = '0;
    corner_ch.pos_y        = '0;
    corner_ch.pos_z        = '0;
    corner_ch.tex_u        = '0;
    corner_ch.tex_v        = '0;
    basis_ch.ready         = 1'b0;
    held_count             = 0;
    mismatch_count         = 0;
    steady_flow            = 1'b0;
    stall_cycles           = 0;
    cycle_count            = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_output_stall();
    test_random(590);

    corner_ch.valid <= 1'b0;
    while (pending_bases.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);

    if (mismatch_count == 0 && pending_bases.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
